### rtl/core/rts_pkg.sv
// Shared definitions for the rectangle translate / scale / rotate block.
// Holds default parameter values, field widths, opcodes and the quarter-wave sine table.
// No dependencies.
`default_nettype none

package rts_pkg;

  // Default values for the top-level parameters.
  localparam int COORD_BITS_DEF = 16;
  localparam int SCALE_FRAC_DEF = 8;
  localparam int TRIG_FRAC_DEF  = 14;

  // Fixed field widths.
  localparam int OP_BITS    = 2;
  localparam int SCALE_BITS = 16;
  localparam int ANGLE_BITS = 9;

  // The sine table is stored with this many fraction bits.
  localparam int TABLE_FRAC = 14;
  localparam int TABLE_IDX_BITS = 7;

  // Angle landmarks in whole degrees.
  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF    = 180;
  localparam int DEG_3Q      = 270;
  localparam int DEG_FULL    = 360;

  typedef enum logic [OP_BITS-1:0] {
    OP_TRANSLATE = 2'd0,
    OP_SCALE     = 2'd1,
    OP_ROTATE    = 2'd2,
    OP_PASS      = 2'd3
  } opcode_t;

  // round(sin(d) * 16384) for d = 0..90 degrees.
  localparam logic [14:0] SINE_Q14 [0:90] = '{
        15'd0,   15'd286,   15'd572,   15'd857,  15'd1143,  15'd1428,  15'd1713,
     15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
     15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
     15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
     15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
     15'd9397,  15'd9630,  15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

endpackage

`default_nettype wire

### rtl/core/rect_translate_scale_rotate.sv
// Each word passes through four register stages (input, trig/midpoint, multiply,
// sum/saturate) on its way to the master side; each stage holds one word and advances
// when it is empty or the stage after it advances. Throughput: one word per cycle
// while the master side is ready.
// Reset clears the stage valid bits only; data registers are not reset.
// Depends on rts_pkg.
`default_nettype none

module rect_translate_scale_rotate #(
  parameter int COORD_BITS      = rts_pkg::COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = rts_pkg::SCALE_FRAC_DEF,
  parameter int TRIG_FRAC_BITS  = rts_pkg::TRIG_FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // x_first, y_first, x_second, y_second, shift_amount (COORD_BITS each),
  // scale_factor (16), angle_degrees (9), zero padding
  input  logic [((5*COORD_BITS + rts_pkg::SCALE_BITS + rts_pkg::ANGLE_BITS + 7) / 8) * 8 - 1:0]
               s_tdata,
  // opcode (2)
  input  logic [rts_pkg::OP_BITS-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // new_x_first, new_y_first, new_x_second, new_y_second (COORD_BITS each), zero padding
  output logic [((4*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  // clipped (1)
  output logic m_tuser
);
  import rts_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int SF    = SCALE_FRAC_BITS;
  localparam int TF    = TRIG_FRAC_BITS;
  localparam int DW    = CW + 1;            // corner offset from midpoint
  localparam int KW    = TF + 2;            // signed sine / cosine
  localparam int PW    = DW + KW;           // rotate product
  localparam int SW    = CW + SCALE_BITS + 1;  // scale product
  localparam int AW    = CW + TF + 4;       // rotate sum
  localparam int RW    = SW;                // common result width before saturation
  localparam int OUT_W = ((4*CW + 7) / 8) * 8;

  // Rescaling the stored table to the chosen trig precision.
  localparam int TRIG_UP   = (TF >= TABLE_FRAC) ? TF - TABLE_FRAC : 0;
  localparam int TRIG_DN   = (TF < TABLE_FRAC) ? TABLE_FRAC - TF : 0;
  localparam int TRIG_HALF = (1 << TRIG_DN) >> 1;

  localparam logic signed [AW-1:0] ROT_BIAS   = AW'((1 << TF) - 1);
  localparam logic signed [SW-1:0] SCALE_BIAS = SW'((1 << SF) - 1);

  localparam logic signed [RW-1:0] SAT_HI = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] COORD_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_LO = {1'b1, {(CW-1){1'b0}}};

  // Table magnitude at the chosen precision, rounded half up when narrowing.
  function automatic logic [TF:0] trig_mag(input logic [TABLE_IDX_BITS-1:0] idx);
    logic [31:0] tmp;
    tmp = ((32'(SINE_Q14[idx]) + 32'(TRIG_HALF)) >> TRIG_DN) << TRIG_UP;
    return tmp[TF:0];
  endfunction

  // Signed sine of a whole angle in 0..359 degrees.
  function automatic logic signed [KW-1:0] sine_of(input logic [ANGLE_BITS-1:0] a);
    logic [TABLE_IDX_BITS-1:0] idx;
    logic                      neg;
    logic signed [KW-1:0]      mag;
    if (a <= DEG_QUARTER) begin
      idx = TABLE_IDX_BITS'(a);
      neg = 1'b0;
    end else if (a <= DEG_HALF) begin
      idx = TABLE_IDX_BITS'(DEG_HALF - a);
      neg = 1'b0;
    end else if (a <= DEG_3Q) begin
      idx = TABLE_IDX_BITS'(a - DEG_HALF);
      neg = 1'b1;
    end else begin
      idx = TABLE_IDX_BITS'(DEG_FULL - a);
      neg = 1'b1;
    end
    mag = $signed({1'b0, trig_mag(idx)});
    return neg ? -mag : mag;
  endfunction

  // Clamp to the coordinate range; the top bit reports a clamp.
  function automatic logic [CW:0] saturate(input logic signed [RW-1:0] v);
    logic [CW:0] res;
    if (v > SAT_HI) begin
      res = {1'b1, SAT_HI[CW-1:0]};
    end else if (v < SAT_LO) begin
      res = {1'b1, SAT_LO[CW-1:0]};
    end else begin
      res = {1'b0, v[CW-1:0]};
    end
    return res;
  endfunction

  // Stage valid bits and advance enables.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4      = !v4 || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: input register.
  opcode_t                 s1_op;
  logic signed [CW-1:0]    s1_c [4];
  logic signed [CW-1:0]    s1_t;
  logic [SCALE_BITS-1:0]   s1_f;
  logic [ANGLE_BITS-1:0]   s1_a;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op <= opcode_t'(s_tuser);
      for (int i = 0; i < 4; i++) begin
        s1_c[i] <= s_tdata[i*CW +: CW];
      end
      s1_t <= s_tdata[4*CW +: CW];
      s1_f <= s_tdata[5*CW +: SCALE_BITS];
      s1_a <= s_tdata[5*CW + SCALE_BITS +: ANGLE_BITS];
    end
  end

  // Stage 2 logic: angle wrap, trig lookup, midpoint, offsets and translate sums.
  logic [ANGLE_BITS-1:0] ang_mod, ang_cos_sum, ang_cos;
  logic signed [CW:0]    mid_x_sum, mid_y_sum, mid_x_half, mid_y_half;

  always_comb begin
    ang_mod     = (s1_a >= DEG_FULL) ? ANGLE_BITS'(s1_a - DEG_FULL) : s1_a;
    ang_cos_sum = ANGLE_BITS'(ang_mod + DEG_QUARTER);
    ang_cos     = (ang_cos_sum >= DEG_FULL) ? ANGLE_BITS'(ang_cos_sum - DEG_FULL) : ang_cos_sum;
    mid_x_sum   = (CW+1)'(s1_c[0]) + (CW+1)'(s1_c[2]);
    mid_y_sum   = (CW+1)'(s1_c[1]) + (CW+1)'(s1_c[3]);
    // Halving truncates toward zero.
    mid_x_half  = mid_x_sum[CW] ? (mid_x_sum + (CW+1)'(1)) >>> 1 : mid_x_sum >>> 1;
    mid_y_half  = mid_y_sum[CW] ? (mid_y_sum + (CW+1)'(1)) >>> 1 : mid_y_sum >>> 1;
  end

  opcode_t                 s2_op;
  logic signed [CW-1:0]    s2_c [4];
  logic signed [CW:0]      s2_tr [4];
  logic signed [DW-1:0]    s2_d [4];
  logic [SCALE_BITS-1:0]   s2_f;
  logic signed [KW-1:0]    s2_sin, s2_cos;
  logic signed [CW-1:0]    s2_mx, s2_my;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op  <= s1_op;
      s2_f   <= s1_f;
      s2_sin <= sine_of(ang_mod);
      s2_cos <= sine_of(ang_cos);
      s2_mx  <= mid_x_half[CW-1:0];
      s2_my  <= mid_y_half[CW-1:0];
      for (int i = 0; i < 4; i++) begin
        s2_c[i]  <= s1_c[i];
        s2_tr[i] <= (CW+1)'(s1_c[i]) + (CW+1)'(s1_t);
      end
      // The midpoint keeps its sign so negative centers subtract correctly.
      s2_d[0] <= DW'(s1_c[0]) - mid_x_half;
      s2_d[1] <= DW'(s1_c[1]) - mid_y_half;
      s2_d[2] <= DW'(s1_c[2]) - mid_x_half;
      s2_d[3] <= DW'(s1_c[3]) - mid_y_half;
    end
  end

  // Stage 3: products for rotate and scale.
  opcode_t                 s3_op;
  logic signed [CW-1:0]    s3_c [4];
  logic signed [CW:0]      s3_tr [4];
  logic signed [CW-1:0]    s3_mx, s3_my;
  logic signed [PW-1:0]    s3_pc [4];
  logic signed [PW-1:0]    s3_ps [4];
  logic signed [SW-1:0]    s3_sc [4];

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_op <= s2_op;
      s3_mx <= s2_mx;
      s3_my <= s2_my;
      for (int i = 0; i < 4; i++) begin
        s3_c[i]  <= s2_c[i];
        s3_tr[i] <= s2_tr[i];
        s3_pc[i] <= PW'(s2_d[i]) * PW'(s2_cos);
        s3_ps[i] <= PW'(s2_d[i]) * PW'(s2_sin);
        s3_sc[i] <= SW'(s2_c[i]) * SW'($signed({1'b0, s2_f}));
      end
    end
  end

  // Stage 4 logic: sums, truncating shifts, opcode select and saturation.
  logic signed [AW-1:0] rot_acc [4];
  logic signed [AW-1:0] rot_q [4];
  logic signed [SW-1:0] sc_q [4];
  logic signed [RW-1:0] res [4];
  logic [CW:0]          sat [4];
  logic [OUT_W-1:0]     out_data_next;
  logic                 clip_next;

  always_comb begin
    // Both formulas of a corner use its original offsets.
    for (int k = 0; k < 2; k++) begin
      rot_acc[2*k]   = (AW'(s3_mx) <<< TF) + AW'(s3_pc[2*k]) - AW'(s3_ps[2*k+1]);
      rot_acc[2*k+1] = (AW'(s3_my) <<< TF) + AW'(s3_ps[2*k]) + AW'(s3_pc[2*k+1]);
    end
    for (int i = 0; i < 4; i++) begin
      rot_q[i] = rot_acc[i][AW-1] ? (rot_acc[i] + ROT_BIAS) >>> TF : rot_acc[i] >>> TF;
      sc_q[i]  = s3_sc[i][SW-1] ? (s3_sc[i] + SCALE_BIAS) >>> SF : s3_sc[i] >>> SF;
      unique case (s3_op)
        OP_TRANSLATE: res[i] = RW'(s3_tr[i]);
        OP_SCALE:     res[i] = RW'(sc_q[i]);
        OP_ROTATE:    res[i] = RW'(rot_q[i]);
        OP_PASS:      res[i] = RW'(s3_c[i]);
        default:      res[i] = RW'(s3_c[i]);
      endcase
      sat[i] = saturate(res[i]);
    end
    out_data_next = '0;
    for (int i = 0; i < 4; i++) begin
      out_data_next[i*CW +: CW] = sat[i][CW-1:0];
    end
    clip_next = sat[0][CW] | sat[1][CW] | sat[2][CW] | sat[3][CW];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (en4) begin
      m_tdata <= out_data_next;
      m_tuser <= clip_next;
    end
  end

  // A clipped word carries at least one coordinate sitting on a range bound.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[0*CW +: CW] == COORD_HI || m_tdata[0*CW +: CW] == COORD_LO ||
      m_tdata[1*CW +: CW] == COORD_HI || m_tdata[1*CW +: CW] == COORD_LO ||
      m_tdata[2*CW +: CW] == COORD_HI || m_tdata[2*CW +: CW] == COORD_LO ||
      m_tdata[3*CW +: CW] == COORD_HI || m_tdata[3*CW +: CW] == COORD_LO)
    else $error("clipped flag set without a saturated coordinate");

  // A ready sink never stalls the slave side.
  assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("slave side stalled while master side is ready");

  // An accepted word reaches the output when the master side stays ready behind it.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("accepted word did not reach the output in time");

endmodule

`default_nettype wire

### verif/rect_translate_scale_rotate_checker.sv
// Checker for the rectangle translate / scale / rotate block: watches both stream channels,
// predicts each result word from the accepted input word and compares them field by field.
// Depends on rts_pkg for widths, opcodes and the quarter-wave sine table.
`timescale 1ns / 1ps

module rect_translate_scale_rotate_checker #(
  parameter int COORD_BITS      = rts_pkg::COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = rts_pkg::SCALE_FRAC_DEF,
  parameter int TRIG_FRAC_BITS  = rts_pkg::TRIG_FRAC_DEF,
  parameter int S_BITS          = ((5*COORD_BITS + rts_pkg::SCALE_BITS
                                    + rts_pkg::ANGLE_BITS + 7) / 8) * 8,
  parameter int M_BITS          = ((4*COORD_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  // x_first, y_first, x_second, y_second, shift_amount, scale_factor, angle_degrees
  input  logic [S_BITS-1:0]           s_tdata,
  // opcode
  input  logic [rts_pkg::OP_BITS-1:0] s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // new_x_first, new_y_first, new_x_second, new_y_second
  input  logic [M_BITS-1:0]           m_tdata,
  // clipped
  input  logic                        m_tuser,
  output int                          errors,
  output int                          pending
);
  import rts_pkg::*;

  localparam int CW = COORD_BITS;

  // One input word, unpacked.
  typedef struct {
    opcode_t                op;
    logic signed [CW-1:0]   corner [4];
    logic signed [CW-1:0]   shift;
    logic [SCALE_BITS-1:0]  scale;
    logic [ANGLE_BITS-1:0]  angle;
  } rect_item_t;

  // One result word: x1, y1, x2, y2 and the clip flag.
  typedef struct {
    logic [CW-1:0] corner [4];
    logic          clip;
  } corners_t;

  corners_t expected_corners [$];

  // Sine magnitude for 0..90 degrees, brought to the trig fraction width.
  function automatic longint trig_mag(int d);
    longint v;
    v = longint'(SINE_Q14[d]);
    if (TRIG_FRAC_BITS >= TABLE_FRAC)
      return v * (longint'(1) << (TRIG_FRAC_BITS - TABLE_FRAC));
    else
      return (v + (longint'(1) << (TABLE_FRAC - 1 - TRIG_FRAC_BITS)))
             / (longint'(1) << (TABLE_FRAC - TRIG_FRAC_BITS));
  endfunction

  // Signed sine of a whole angle in 0..359 degrees, folded onto the quarter wave.
  function automatic longint sine_deg(int a);
    if (a <= DEG_QUARTER) return trig_mag(a);
    else if (a <= DEG_HALF) return trig_mag(DEG_HALF - a);
    else if (a <= DEG_3Q) return -trig_mag(a - DEG_HALF);
    else return -trig_mag(DEG_FULL - a);
  endfunction

  function automatic rect_item_t unpack_item(logic [S_BITS-1:0] d, logic [OP_BITS-1:0] u);
    rect_item_t it;
    it.op = opcode_t'(u);
    for (int i = 0; i < 4; i++) it.corner[i] = d[i*CW +: CW];
    it.shift = d[4*CW +: CW];
    it.scale = d[5*CW +: SCALE_BITS];
    it.angle = d[5*CW + SCALE_BITS +: ANGLE_BITS];
    return it;
  endfunction

  // Transformed and saturated corners of one rectangle.
  function automatic corners_t transform_rect(rect_item_t it);
    corners_t res;
    longint c [4];
    longint r [4];
    longint hi, lo, s, co, one, mx, my, dx, dy;
    int a;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    one = longint'(1) << TRIG_FRAC_BITS;
    for (int i = 0; i < 4; i++) c[i] = longint'(it.corner[i]);
    case (it.op)
      OP_TRANSLATE: begin
        for (int i = 0; i < 4; i++) r[i] = c[i] + longint'(it.shift);
      end
      OP_SCALE: begin
        // Signed division truncates toward zero, as the block does.
        for (int i = 0; i < 4; i++)
          r[i] = (c[i] * longint'(it.scale)) / (longint'(1) << SCALE_FRAC_BITS);
      end
      OP_ROTATE: begin
        a = int'(it.angle) % DEG_FULL;
        s = sine_deg(a);
        co = sine_deg((a + DEG_QUARTER) % DEG_FULL);
        mx = (c[0] + c[2]) / 2;
        my = (c[1] + c[3]) / 2;
        for (int i = 0; i < 4; i += 2) begin
          dx = c[i] - mx;
          dy = c[i+1] - my;
          r[i]   = (mx * one + dx * co - dy * s) / one;
          r[i+1] = (my * one + dx * s + dy * co) / one;
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) r[i] = c[i];
      end
    endcase
    res.clip = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (r[i] > hi) begin
        r[i] = hi;
        res.clip = 1'b1;
      end
      if (r[i] < lo) begin
        r[i] = lo;
        res.clip = 1'b1;
      end
      res.corner[i] = r[i][CW-1:0];
    end
    return res;
  endfunction

  string coord_name [4] = '{"new_x_first", "new_y_first", "new_x_second", "new_y_second"};

  initial begin
    errors = 0;
    pending = 0;
  end

  // Predict on input accepts, compare on output accepts.
  always @(posedge clk) begin
    corners_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_corners.push_back(transform_rect(unpack_item(s_tdata, s_tuser)));
      if (m_tvalid && m_tready) begin
        if (expected_corners.size() == 0) begin
          $display("%0t: unexpected result word %h clipped %b", $time, m_tdata, m_tuser);
          errors = errors + 1;
        end else begin
          want = expected_corners.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (m_tdata[i*CW +: CW] !== want.corner[i]) begin
              $display("%0t: %s expected %0d actual %0d", $time, coord_name[i],
                       $signed(want.corner[i]), $signed(m_tdata[i*CW +: CW]));
              errors = errors + 1;
            end
          end
          if (m_tuser !== want.clip) begin
            $display("%0t: clipped expected %b actual %b", $time, want.clip, m_tuser);
            errors = errors + 1;
          end
        end
      end
    end
    pending <= expected_corners.size();
  end

endmodule

### verif/rect_translate_scale_rotate_test.sv
// Top of the testbench for rect_translate_scale_rotate: drives directed and random rectangles
// with random idling on both sides and gives the verdict from the checker's failure count.
// Depends on rts_pkg, the block and rect_translate_scale_rotate_checker.
`timescale 1ns / 1ps

module rect_translate_scale_rotate_test;
  import rts_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int S_BITS      = ((5*CW + SCALE_BITS + ANGLE_BITS + 7) / 8) * 8;
  localparam int M_BITS      = ((4*CW + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 900;
  localparam int CALM_WORDS   = 150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [S_BITS-1:0] s_tdata = '0;
  logic [OP_BITS-1:0] s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [M_BITS-1:0] m_tdata;
  logic              m_tuser;

  int errors;
  int pending;
  int sent_count = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rect_translate_scale_rotate dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  rect_translate_scale_rotate_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one rectangle word and hold it until the block takes it.
  task automatic offer_rect(opcode_t op, int x1, int y1, int x2, int y2,
                            int shift, int scale, int angle);
    s_tdata <= {{(S_BITS - 5*CW - SCALE_BITS - ANGLE_BITS){1'b0}}, ANGLE_BITS'(angle),
                SCALE_BITS'(scale), CW'(shift), CW'(y2), CW'(x2), CW'(y1), CW'(x1)};
    s_tuser <= op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent_count = sent_count + 1;
  endtask

  // Coordinates lean toward small and medium values, with the extremes mixed in.
  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32767;
          1: return -32768;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2, 3: return $urandom_range(0, 400) - 200;
      4, 5: return $urandom_range(0, 8000) - 4000;
      default: return int'($urandom() & 32'hFFFF);
    endcase
  endfunction

  function automatic int pick_scale();
    case ($urandom_range(0, 5))
      0: return ($urandom_range(0, 1) == 0) ? 0 : 16'hFFFF;
      1, 2: return $urandom_range(0, 512);
      default: return int'($urandom() & 32'hFFFF);
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold-off, and always ready in the calm tail.
  initial begin : sink
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if (!held && sent_count >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : source
    opcode_t op;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Translate at the edges of the range, including saturation both ways.
    offer_rect(OP_TRANSLATE, 0, 0, 0, 0, 0, 0, 0);
    offer_rect(OP_TRANSLATE, 32767, 32767, 32767, 32767, 1, 0, 0);
    offer_rect(OP_TRANSLATE, -32768, -32768, -32768, -32768, -1, 0, 0);
    offer_rect(OP_TRANSLATE, 32767, -32768, -32768, 32767, -32768, 16'hFFFF, 511);
    offer_rect(OP_TRANSLATE, -32768, 32767, 0, -1, 32767, 0, 0);
    // Scale: zero factor, largest factor, identity and truncation toward zero.
    offer_rect(OP_SCALE, 32767, -32768, -1, 1, 0, 0, 0);
    offer_rect(OP_SCALE, 32767, -32768, 1, -1, 0, 16'hFFFF, 0);
    offer_rect(OP_SCALE, 32767, -32768, 123, -456, 0, 256, 0);
    offer_rect(OP_SCALE, -1, 1, -255, 255, 0, 1, 0);
    offer_rect(OP_SCALE, -3, 3, -32768, 32767, 0, 16'h0080, 0);
    // Rotate at the quadrant landmarks, with wrap past a full turn.
    offer_rect(OP_ROTATE, -100, -50, 100, 50, 0, 0, 0);
    offer_rect(OP_ROTATE, -32768, -32768, 32767, 32767, 0, 0, DEG_QUARTER);
    offer_rect(OP_ROTATE, -32768, 0, 32767, 100, 0, 0, DEG_HALF);
    offer_rect(OP_ROTATE, 32767, -32768, -32768, 32767, 0, 0, DEG_3Q);
    offer_rect(OP_ROTATE, 1000, -2000, -3000, 4000, 0, 0, 359);
    offer_rect(OP_ROTATE, 1000, -2000, -3000, 4000, 0, 0, DEG_FULL);
    offer_rect(OP_ROTATE, 1000, -2000, -3000, 4000, 0, 0, 511);
    offer_rect(OP_ROTATE, 32767, 32767, -32768, -32768, 32767, 16'hFFFF, 45);
    // Odd negative sums exercise the truncating midpoint.
    offer_rect(OP_ROTATE, -3, -5, 0, 0, 0, 0, 30);
    // The unused opcode passes the corners through.
    offer_rect(OP_PASS, 32767, -32768, -1, 0, 32767, 16'hFFFF, 511);
    offer_rect(OP_PASS, -32768, 32767, 0, -1, -1, 0, 0);

    // Random words with sender gaps; the tail runs with no idling at all.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      if ($urandom_range(0, 15) == 0) op = OP_PASS;
      else op = opcode_t'($urandom_range(OP_TRANSLATE, OP_ROTATE));
      offer_rect(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 ($urandom_range(0, 1) == 0) ? pick_coord() : int'($urandom() & 32'hFFFF),
                 pick_scale(), $urandom_range(0, (1 << ANGLE_BITS) - 1));
      if (!calm && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then let the pipeline settle before the verdict.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
